@@ hdl/rbg_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and state codes for the RMS balance gain block.
package rbg_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int COEFF_WIDTH     = 24;
    localparam int POWER_WIDTH     = 40;
    localparam int GAIN_WIDTH      = 24;
    localparam int QUO_WIDTH       = 48;
    localparam int ROOT_REM_WIDTH  = 24;
    localparam int PROD_WIDTH      = 41;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CNT_WIDTH       = 6;

    localparam int MUL_STEPS  = POWER_WIDTH;
    localparam int DIV_STEPS  = QUO_WIDTH;
    localparam int ROOT_STEPS = QUO_WIDTH / 2;

    localparam logic [COEFF_WIDTH-1:0] INPUT_WEIGHT_RESET = 24'd21945;
    localparam logic [COEFF_WIDTH-1:0] SMOOTH_COEFF_RESET = 24'd16755271;
    localparam logic [POWER_WIDTH-1:0] POWER_MAX          = {POWER_WIDTH{1'b1}};
    localparam logic [GAIN_WIDTH-1:0]  GAIN_MAX           = {GAIN_WIDTH{1'b1}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INPUT_WEIGHT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SMOOTH_COEFF = 2'd1;

    typedef struct packed {
        logic load;
        logic step;
    } unit_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_DIV_END,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

@@ hdl/rbg_smul.sv @@
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier returning the product scaled down by the coefficient width.
module rbg_smul (
    input  logic                                clk,
    input  rbg_pkg::unit_ctrl_t                 ctrl,
    input  logic [rbg_pkg::COEFF_WIDTH-1:0]     mcand,
    input  logic [rbg_pkg::POWER_WIDTH-1:0]     mplier,
    output logic [rbg_pkg::POWER_WIDTH-1:0]     scaled
);

    logic [rbg_pkg::COEFF_WIDTH-1:0] mcand_reg;
    logic [rbg_pkg::COEFF_WIDTH-1:0] hi_reg;
    logic [rbg_pkg::COEFF_WIDTH-1:0] hi_next;
    logic [rbg_pkg::POWER_WIDTH-1:0] lo_reg;
    logic [rbg_pkg::POWER_WIDTH-1:0] lo_next;
    logic [rbg_pkg::COEFF_WIDTH:0]   partial;

    always_comb
    begin
        partial = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        hi_next = partial[rbg_pkg::COEFF_WIDTH:1];
        lo_next = {partial[0], lo_reg[rbg_pkg::POWER_WIDTH-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (ctrl.step)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign scaled = {hi_reg, lo_reg[rbg_pkg::POWER_WIDTH-1:rbg_pkg::COEFF_WIDTH]};

endmodule

@@ hdl/rbg_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the power ratio scaled by 2^32.
module rbg_div (
    input  logic                                clk,
    input  rbg_pkg::unit_ctrl_t                 ctrl,
    input  logic [rbg_pkg::POWER_WIDTH-1:0]     dividend,
    input  logic [rbg_pkg::POWER_WIDTH-1:0]     divisor,
    output logic [rbg_pkg::QUO_WIDTH-1:0]       quotient
);

    logic [rbg_pkg::POWER_WIDTH-1:0] rem_reg;
    logic [rbg_pkg::POWER_WIDTH-1:0] rem_next;
    logic [rbg_pkg::POWER_WIDTH-1:0] dsr_reg;
    logic [rbg_pkg::QUO_WIDTH-1:0]   dvd_reg;
    logic [rbg_pkg::QUO_WIDTH-1:0]   dvd_next;
    logic [rbg_pkg::POWER_WIDTH:0]   trial;
    logic [rbg_pkg::POWER_WIDTH+1:0] diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[rbg_pkg::QUO_WIDTH-1]};
        diff  = {1'b0, trial} - {2'b00, dsr_reg};
        if (!diff[rbg_pkg::POWER_WIDTH+1])
        begin
            rem_next = diff[rbg_pkg::POWER_WIDTH-1:0];
            dvd_next = {dvd_reg[rbg_pkg::QUO_WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[rbg_pkg::POWER_WIDTH-1:0];
            dvd_next = {dvd_reg[rbg_pkg::QUO_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= {16'd0, dividend[rbg_pkg::POWER_WIDTH-1:16]};
            dvd_reg <= {dividend[15:0], 32'd0};
            dsr_reg <= divisor;
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign quotient = dvd_reg;

endmodule

@@ hdl/rbg_sqrt.sv @@
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one root bit per cycle.
module rbg_sqrt (
    input  logic                                clk,
    input  rbg_pkg::unit_ctrl_t                 ctrl,
    input  logic [rbg_pkg::QUO_WIDTH-1:0]       radicand,
    output logic [rbg_pkg::GAIN_WIDTH-1:0]      root
);

    logic [rbg_pkg::QUO_WIDTH-1:0]      rad_reg;
    logic [rbg_pkg::ROOT_REM_WIDTH-1:0] rem_reg;
    logic [rbg_pkg::ROOT_REM_WIDTH-1:0] rem_next;
    logic [rbg_pkg::GAIN_WIDTH-1:0]     root_reg;
    logic [rbg_pkg::GAIN_WIDTH-1:0]     root_next;
    logic [rbg_pkg::ROOT_REM_WIDTH+1:0] trial_rem;
    logic [rbg_pkg::GAIN_WIDTH+1:0]     test;
    logic [rbg_pkg::GAIN_WIDTH+2:0]     diff;

    always_comb
    begin
        trial_rem = {rem_reg, rad_reg[rbg_pkg::QUO_WIDTH-1:rbg_pkg::QUO_WIDTH-2]};
        test      = {root_reg, 2'b01};
        diff      = {1'b0, trial_rem} - {1'b0, test};
        if (!diff[rbg_pkg::GAIN_WIDTH+2])
        begin
            rem_next  = diff[rbg_pkg::ROOT_REM_WIDTH-1:0];
            root_next = {root_reg[rbg_pkg::GAIN_WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_next  = trial_rem[rbg_pkg::ROOT_REM_WIDTH-1:0];
            root_next = {root_reg[rbg_pkg::GAIN_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (ctrl.step)
        begin
            rad_reg  <= {rad_reg[rbg_pkg::QUO_WIDTH-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule

@@ hdl/rms_balance_gain.sv @@
`timescale 1ns / 1ps
// Top level of the RMS balance gain block: trackers, gain sequencer and channel registers.
//
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | signal_sample, compare_sample
//  out     | out_valid / out_stall | balanced_sample
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// When the gain goes through the divider, an item passes from one acceptance to the next through
// the bit-serial tracker multiplies, the restoring divider, the square root and the control states.
// With zero signal power the divider is skipped; with a saturated gain the square root is also skipped.
// Reset restores the default coefficients and clears both power trackers and the held gain.
// in_stall stays high while an item is in flight; the result then waits in the output register,
// and the last cycle of an item holds while that register is full and out_stall is high.
module rms_balance_gain (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [rbg_pkg::SAMPLE_WIDTH-1:0] signal_sample,
    input  logic signed [rbg_pkg::SAMPLE_WIDTH-1:0] compare_sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [rbg_pkg::SAMPLE_WIDTH-1:0] balanced_sample,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [rbg_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [rbg_pkg::COEFF_WIDTH-1:0]         cfg_data
);

    rbg_pkg::state_t state_reg;
    rbg_pkg::state_t state_next;
    logic [rbg_pkg::CNT_WIDTH-1:0] count_reg;
    logic [rbg_pkg::CNT_WIDTH-1:0] count_next;

    logic [rbg_pkg::COEFF_WIDTH-1:0] input_weight_reg;
    logic [rbg_pkg::COEFF_WIDTH-1:0] smooth_coeff_reg;
    logic [rbg_pkg::POWER_WIDTH-1:0] signal_power_reg;
    logic [rbg_pkg::POWER_WIDTH-1:0] compare_power_reg;
    logic [rbg_pkg::GAIN_WIDTH-1:0]  held_gain_reg;
    logic [rbg_pkg::GAIN_WIDTH-1:0]  held_gain_next;
    logic                            gain_sat_reg;
    logic signed [rbg_pkg::PROD_WIDTH-1:0] prod_reg;
    logic                            out_valid_reg;
    logic [rbg_pkg::SAMPLE_WIDTH-1:0] balanced_sample_reg;
    logic [rbg_pkg::SAMPLE_WIDTH-1:0] balanced_sample_next;

    rbg_pkg::unit_ctrl_t mul_ctrl;
    rbg_pkg::unit_ctrl_t div_ctrl;
    rbg_pkg::unit_ctrl_t root_ctrl;
    logic root_from_div;
    logic out_load;
    logic in_accept;
    logic cfg_accept;
    logic ratio_ovf;

    logic signed [2*rbg_pkg::SAMPLE_WIDTH-1:0] sq_signal;
    logic signed [2*rbg_pkg::SAMPLE_WIDTH-1:0] sq_compare;
    logic signed [rbg_pkg::PROD_WIDTH-1:0]     prod_next;
    logic [rbg_pkg::POWER_WIDTH-1:0] sig_new_term;
    logic [rbg_pkg::POWER_WIDTH-1:0] sig_old_term;
    logic [rbg_pkg::POWER_WIDTH-1:0] cmp_new_term;
    logic [rbg_pkg::POWER_WIDTH-1:0] cmp_old_term;
    logic [rbg_pkg::POWER_WIDTH:0]   sig_sum;
    logic [rbg_pkg::POWER_WIDTH:0]   cmp_sum;
    logic [rbg_pkg::POWER_WIDTH-1:0] signal_power_next;
    logic [rbg_pkg::POWER_WIDTH-1:0] compare_power_next;
    logic [rbg_pkg::QUO_WIDTH-1:0]   quotient;
    logic [rbg_pkg::QUO_WIDTH-1:0]   radicand;
    logic [rbg_pkg::GAIN_WIDTH-1:0]  root;
    logic signed [rbg_pkg::PROD_WIDTH-1:0] rounded;
    logic [rbg_pkg::PROD_WIDTH-32:0] rounded_top;

    assign in_stall   = (state_reg != rbg_pkg::ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_valid  = out_valid_reg;
    assign balanced_sample = balanced_sample_reg;

    assign sq_signal  = signal_sample * signal_sample;
    assign sq_compare = compare_sample * compare_sample;
    assign prod_next  = signal_sample * $signed({1'b0, held_gain_reg});

    rbg_smul u_sig_new (
        .clk    (clk),
        .ctrl   (mul_ctrl),
        .mcand  (input_weight_reg),
        .mplier ({8'd0, sq_signal}),
        .scaled (sig_new_term)
    );

    rbg_smul u_sig_old (
        .clk    (clk),
        .ctrl   (mul_ctrl),
        .mcand  (smooth_coeff_reg),
        .mplier (signal_power_reg),
        .scaled (sig_old_term)
    );

    rbg_smul u_cmp_new (
        .clk    (clk),
        .ctrl   (mul_ctrl),
        .mcand  (input_weight_reg),
        .mplier ({8'd0, sq_compare}),
        .scaled (cmp_new_term)
    );

    rbg_smul u_cmp_old (
        .clk    (clk),
        .ctrl   (mul_ctrl),
        .mcand  (smooth_coeff_reg),
        .mplier (compare_power_reg),
        .scaled (cmp_old_term)
    );

    rbg_div u_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (compare_power_reg),
        .divisor  (signal_power_reg),
        .quotient (quotient)
    );

    assign radicand = root_from_div ? quotient : {6'd0, compare_power_reg, 2'b00};

    rbg_sqrt u_sqrt (
        .clk      (clk),
        .ctrl     (root_ctrl),
        .radicand (radicand),
        .root     (root)
    );

    always_comb
    begin
        sig_sum = {1'b0, sig_new_term} + {1'b0, sig_old_term};
        cmp_sum = {1'b0, cmp_new_term} + {1'b0, cmp_old_term};
        signal_power_next  = sig_sum[rbg_pkg::POWER_WIDTH] ? rbg_pkg::POWER_MAX
                                                           : sig_sum[rbg_pkg::POWER_WIDTH-1:0];
        compare_power_next = cmp_sum[rbg_pkg::POWER_WIDTH] ? rbg_pkg::POWER_MAX
                                                           : cmp_sum[rbg_pkg::POWER_WIDTH-1:0];
        ratio_ovf = ({16'd0, compare_power_reg[rbg_pkg::POWER_WIDTH-1:16]} >= signal_power_reg);
    end

    always_comb
    begin
        rounded     = prod_reg + 41'sd32768;
        rounded_top = rounded[rbg_pkg::PROD_WIDTH-1:31];
        if ((rounded_top == '0) || (rounded_top == '1))
        begin
            balanced_sample_next = rounded[31:16];
        end
        else if (rounded[rbg_pkg::PROD_WIDTH-1])
        begin
            balanced_sample_next = rbg_pkg::SAMPLE_MIN;
        end
        else
        begin
            balanced_sample_next = rbg_pkg::SAMPLE_MAX;
        end
        held_gain_next = gain_sat_reg ? rbg_pkg::GAIN_MAX : root;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        mul_ctrl      = '0;
        div_ctrl      = '0;
        root_ctrl     = '0;
        root_from_div = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            rbg_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    mul_ctrl.load = 1'b1;
                    count_next    = '0;
                    state_next    = rbg_pkg::ST_MUL;
                end
            end
            rbg_pkg::ST_MUL:
            begin
                mul_ctrl.step = 1'b1;
                if (count_reg == rbg_pkg::CNT_WIDTH'(rbg_pkg::MUL_STEPS - 1))
                begin
                    count_next = '0;
                    state_next = rbg_pkg::ST_SUM;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            rbg_pkg::ST_SUM:
            begin
                state_next = rbg_pkg::ST_CHECK;
            end
            rbg_pkg::ST_CHECK:
            begin
                count_next = '0;
                if (signal_power_reg == '0)
                begin
                    root_ctrl.load = 1'b1;
                    state_next     = rbg_pkg::ST_ROOT;
                end
                else if (ratio_ovf)
                begin
                    state_next = rbg_pkg::ST_DONE;
                end
                else
                begin
                    div_ctrl.load = 1'b1;
                    state_next    = rbg_pkg::ST_DIV;
                end
            end
            rbg_pkg::ST_DIV:
            begin
                div_ctrl.step = 1'b1;
                if (count_reg == rbg_pkg::CNT_WIDTH'(rbg_pkg::DIV_STEPS - 1))
                begin
                    count_next = '0;
                    state_next = rbg_pkg::ST_DIV_END;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            rbg_pkg::ST_DIV_END:
            begin
                root_ctrl.load = 1'b1;
                root_from_div  = 1'b1;
                state_next     = rbg_pkg::ST_ROOT;
            end
            rbg_pkg::ST_ROOT:
            begin
                root_ctrl.step = 1'b1;
                if (count_reg == rbg_pkg::CNT_WIDTH'(rbg_pkg::ROOT_STEPS - 1))
                begin
                    count_next = '0;
                    state_next = rbg_pkg::ST_DONE;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            rbg_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = rbg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= rbg_pkg::ST_IDLE;
            count_reg         <= '0;
            input_weight_reg  <= rbg_pkg::INPUT_WEIGHT_RESET;
            smooth_coeff_reg  <= rbg_pkg::SMOOTH_COEFF_RESET;
            signal_power_reg  <= '0;
            compare_power_reg <= '0;
            held_gain_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_accept && (cfg_index == rbg_pkg::CFG_INPUT_WEIGHT))
            begin
                input_weight_reg <= cfg_data;
            end
            if (cfg_accept && (cfg_index == rbg_pkg::CFG_SMOOTH_COEFF))
            begin
                smooth_coeff_reg <= cfg_data;
            end
            if (state_reg == rbg_pkg::ST_SUM)
            begin
                signal_power_reg  <= signal_power_next;
                compare_power_reg <= compare_power_next;
            end
            if (out_load)
            begin
                held_gain_reg <= held_gain_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == rbg_pkg::ST_CHECK)
        begin
            gain_sat_reg <= (signal_power_reg != '0) && ratio_ovf;
        end
        if (out_load)
        begin
            balanced_sample_reg <= balanced_sample_next;
        end
    end

endmodule

@@ tb/rbg_checker.sv @@
`timescale 1ns / 1ps
// Checker for the RMS balance gain block: tracks powers and gain, predicts and compares outputs.
module rbg_checker
    import rbg_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      signal_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]      compare_sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      balanced_sample,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]          cfg_index,
    input  logic [COEFF_WIDTH-1:0]              cfg_data,
    output int                                  mismatches,
    output int                                  results_due
);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [POWER_WIDTH-1:0]         power_t;
    typedef logic [GAIN_WIDTH-1:0]          gain_t;
    typedef logic [COEFF_WIDTH-1:0]         coeff_t;

    localparam longint OUT_HI = longint'($signed(SAMPLE_MAX));
    localparam longint OUT_LO = longint'($signed(SAMPLE_MIN));

    coeff_t  new_weight;
    coeff_t  feedback_weight;
    power_t  signal_level;
    power_t  compare_level;
    gain_t   gain_hold;
    sample_t pending_balanced[$];

    function automatic power_t track_level(coeff_t w_new, coeff_t w_fb, logic [63:0] square,
                                           power_t prev);
        logic [127:0] sum;
        sum = ((128'(w_new) * 128'(square)) >> COEFF_WIDTH)
            + ((128'(w_fb) * 128'(prev)) >> COEFF_WIDTH);
        return (sum > 128'(POWER_MAX)) ? POWER_MAX : sum[POWER_WIDTH-1:0];
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] radicand);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= radicand)
                root = trial;
        end
        return root;
    endfunction

    function automatic gain_t level_gain(power_t sig_pow, power_t cmp_pow);
        logic [127:0] radicand;
        logic [63:0]  root;
        if (sig_pow == '0)
            radicand = 128'(cmp_pow) << 2;
        else if (128'(cmp_pow) >= (128'(sig_pow) << 16))
            return GAIN_MAX;
        else
            radicand = (128'(cmp_pow) << 32) / 128'(sig_pow);
        root = floor_root(radicand);
        return (root > 64'(GAIN_MAX)) ? GAIN_MAX : root[GAIN_WIDTH-1:0];
    endfunction

    function automatic sample_t apply_gain(sample_t s, gain_t g);
        longint scaled;
        scaled = (longint'(s) * longint'(g) + 64'sd32768) >>> 16;
        if (scaled > OUT_HI)
            scaled = OUT_HI;
        if (scaled < OUT_LO)
            scaled = OUT_LO;
        return sample_t'(scaled);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sample_t     want;
        logic [63:0] sig_sq;
        logic [63:0] cmp_sq;
        power_t      sig_next;
        power_t      cmp_next;
        if (!rst_n)
        begin
            new_weight      = INPUT_WEIGHT_RESET;
            feedback_weight = SMOOTH_COEFF_RESET;
            signal_level    = '0;
            compare_level   = '0;
            gain_hold       = '0;
            pending_balanced.delete();
            mismatches      = 0;
            results_due     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_balanced.size() == 0)
                begin
                    $error("balanced_sample: no result expected, actual %0d", balanced_sample);
                    mismatches++;
                end
                else
                begin
                    want = pending_balanced.pop_front();
                    if (balanced_sample !== want)
                    begin
                        $error("balanced_sample mismatch: expected %0d, actual %0d",
                               want, balanced_sample);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INPUT_WEIGHT: new_weight = cfg_data;
                    CFG_SMOOTH_COEFF: feedback_weight = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                sig_sq   = 64'(longint'(signal_sample) * longint'(signal_sample));
                cmp_sq   = 64'(longint'(compare_sample) * longint'(compare_sample));
                sig_next = track_level(new_weight, feedback_weight, sig_sq, signal_level);
                cmp_next = track_level(new_weight, feedback_weight, cmp_sq, compare_level);
                pending_balanced.push_back(apply_gain(signal_sample, gain_hold));
                gain_hold     = level_gain(sig_next, cmp_next);
                signal_level  = sig_next;
                compare_level = cmp_next;
            end
            results_due = pending_balanced.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Testbench top for the RMS balance gain block: clock, reset, stimulus and verdict.
module testbench;
    import rbg_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef enum int {LEVEL_QUIET, LEVEL_SOFT, LEVEL_LOUD, LEVEL_FULL} level_mode_t;

    localparam int CLK_PERIOD       = 12;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_PER_PHASE = 360;
    localparam int SETTLE_CYCLES    = 150;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [COEFF_WIDTH-1:0]     COEFF_FULL  = {COEFF_WIDTH{1'b1}};
    localparam logic [COEFF_WIDTH-1:0]     COEFF_ZERO  = '0;
    localparam sample_t PEAK_POS = SAMPLE_MAX;
    localparam sample_t PEAK_NEG = SAMPLE_MIN;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    sample_t                    signal_sample;
    sample_t                    compare_sample;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    sample_t                    balanced_sample;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [COEFF_WIDTH-1:0]     cfg_data;

    int          mismatches;
    int          results_due;
    int          cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    rms_balance_gain dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .signal_sample   (signal_sample),
        .compare_sample  (compare_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .balanced_sample (balanced_sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    rbg_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .signal_sample   (signal_sample),
        .compare_sample  (compare_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .balanced_sample (balanced_sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .results_due     (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    function automatic sample_t pick_sample(level_mode_t mode);
        int v;
        case (mode)
            LEVEL_QUIET: v = int'($urandom_range(2)) - 1;
            LEVEL_SOFT:  v = int'($urandom_range(512)) - 256;
            LEVEL_LOUD:
            begin
                case ($urandom_range(3))
                    0: v = int'(PEAK_POS);
                    1: v = int'(PEAK_NEG);
                    default:
                    begin
                        v = int'($urandom_range(16384, 32767));
                        if ($urandom_range(1) == 0)
                            v = -v;
                    end
                endcase
            end
            default: v = int'($urandom);
        endcase
        return sample_t'(v);
    endfunction

    task automatic send_pair(input sample_t sig, input sample_t cmp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        signal_sample  <= sig;
        compare_sample <= cmp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [COEFF_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_coeffs(input logic [COEFF_WIDTH-1:0] weight,
                              input logic [COEFF_WIDTH-1:0] feedback);
        wait_drained();
        write_reg(CFG_INPUT_WEIGHT, weight);
        write_reg(CFG_SMOOTH_COEFF, feedback);
    endtask

    initial
    begin
        int                     sent;
        int                     seg_len;
        level_mode_t            sig_mode;
        level_mode_t            cmp_mode;
        logic [COEFF_WIDTH-1:0] weight;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        signal_sample  = '0;
        compare_sample = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_INPUT_WEIGHT;
        cfg_data       = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 73;

        send_pair(sample_t'(0), sample_t'(0));
        send_pair(sample_t'(0), PEAK_POS);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(sample_t'(1), sample_t'(-1));
        send_pair(sample_t'(-1), sample_t'(0));

        set_coeffs(COEFF_FULL, COEFF_FULL);
        write_reg(CFG_SPARE_A, COEFF_WIDTH'($urandom));
        write_reg(CFG_SPARE_B, COEFF_FULL);
        send_pair(sample_t'(1), PEAK_NEG);
        send_pair(sample_t'(1), PEAK_NEG);
        send_pair(sample_t'(2), PEAK_NEG);
        send_pair(PEAK_POS, PEAK_POS);
        send_pair(PEAK_NEG, sample_t'(0));
        repeat (12) send_pair(PEAK_NEG, PEAK_NEG);

        set_coeffs(COEFF_ZERO, COEFF_ZERO);
        send_pair(PEAK_POS, sample_t'(1));
        send_pair(PEAK_NEG, PEAK_NEG);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    weight = COEFF_WIDTH'($urandom_range(1, 1 << 18));
                    set_coeffs(weight, COEFF_FULL - weight - COEFF_WIDTH'($urandom_range(255)));
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 32;
                    set_coeffs(COEFF_WIDTH'($urandom), COEFF_WIDTH'($urandom));
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_coeffs(INPUT_WEIGHT_RESET, SMOOTH_COEFF_RESET);
                end
            endcase
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                seg_len  = $urandom_range(8, 40);
                sig_mode = level_mode_t'($urandom_range(3));
                cmp_mode = level_mode_t'($urandom_range(3));
                if ($urandom_range(29) == 0)
                    wait_drained();
                repeat (seg_len) send_pair(pick_sample(sig_mode), pick_sample(cmp_mode));
                sent += seg_len;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0 && results_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/rbg_pkg.sv
hdl/rbg_smul.sv
hdl/rbg_div.sv
hdl/rbg_sqrt.sv
hdl/rms_balance_gain.sv
tb/rbg_checker.sv
tb/testbench.sv
